FILE: design/vnh_pkg.sv
// Shared constants, register codes and the division step for the hashed value noise block.
// Used by every module of the block; depends on nothing.
package vnh_pkg;

   localparam int COORD_W   = 32;
   localparam int MAG_W     = COORD_W - 1;
   localparam int SCALE_W   = 16;
   localparam int FRAC_BITS = 16;
   localparam int CORNER_W  = 16;
   localparam int WORD_W    = 64;
   localparam int HALF_W    = WORD_W / 2;

   localparam logic [WORD_W-1:0] MIX_C1  = 64'hbf58476d1ce4e5b9;
   localparam logic [WORD_W-1:0] MIX_C2  = 64'h94d049bb133111eb;
   localparam logic [WORD_W-1:0] HASH_KX = 64'h632be59bd9b4e019;
   localparam logic [WORD_W-1:0] HASH_KZ = 64'h8cb92baa3f3d8dd7;
   localparam logic [WORD_W-1:0] HASH_KX1 = HASH_KX + 64'd1;
   localparam logic [WORD_W-1:0] HASH_KZ1 = HASH_KZ + 64'd1;

   localparam logic [WORD_W-1:0]  SEED_RESET  = 64'd0;
   localparam logic [WORD_W-1:0]  SALT_RESET  = 64'd1938907459;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd96;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // Register index, taken from address bits 4..3 (registers sit 8 bytes apart).
   typedef enum logic [1:0] {
      REG_WORLD_SEED = 2'd0,
      REG_NOISE_SALT = 2'd1,
      REG_CELL_SCALE = 2'd2
   } reg_index_type;

   localparam int DIV_LAT    = 1 + MAG_W + 1 + FRAC_BITS;
   localparam int MIX_LAT    = 4;
   localparam int SMOOTH_LAT = 3;
   localparam int HASH_LAT   = 1 + MIX_LAT + 1 + MIX_LAT;
   localparam int PIPE_LAT   = DIV_LAT + HASH_LAT + 2;

   typedef struct packed {
      logic               qbit;
      logic [SCALE_W-1:0] rem;
   } div_step_type;

   // One restoring division step: shift a bit into the remainder and subtract if it fits.
   function automatic div_step_type div_step(input logic [SCALE_W-1:0] rem,
                                             input logic bit_in,
                                             input logic [SCALE_W-1:0] scale);
      logic [SCALE_W:0] trial;
      logic [SCALE_W:0] diff;
      div_step_type     res;
      trial = {rem, bit_in};
      diff  = trial - {1'b0, scale};
      if (trial >= {1'b0, scale}) begin
         res.qbit = 1'b1;
         res.rem  = diff[SCALE_W-1:0];
      end else begin
         res.qbit = 1'b0;
         res.rem  = trial[SCALE_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: design/vnh_divider.sv
// Pipelined floor division of one signed coordinate by the cell scale, one bit per stage.
// Gives the lattice cell and the Q0.FRAC_BITS fraction; depends on vnh_pkg.
module vnh_divider import vnh_pkg::*; (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [COORD_W-1:0]  coord,
   input  logic [SCALE_W-1:0]         scale,
   output logic signed [COORD_W-1:0]  cell_idx,
   output logic [FRAC_BITS-1:0]       frac
);

   // Prepare stage: magnitude word (one's complement for negative inputs).
   logic [MAG_W-1:0]   mag0_ff;
   logic [SCALE_W-1:0] scl0_ff;
   logic               neg0_ff;

   // Quotient stages: the word shifts out dividend bits and takes in quotient bits.
   logic [MAG_W-1:0]   qw_ff   [MAG_W];
   logic [MAG_W-1:0]   qw_in   [MAG_W];
   logic [SCALE_W-1:0] qrem_ff [MAG_W];
   logic [SCALE_W-1:0] qrem_in [MAG_W];
   logic [SCALE_W-1:0] qscl_ff [MAG_W];
   logic               qneg_ff [MAG_W];

   // Correction stage.
   logic signed [COORD_W-1:0] ccell_ff;
   logic [SCALE_W-1:0]        crem_ff;
   logic [SCALE_W-1:0]        cscl_ff;
   logic signed [COORD_W-1:0] ccell_in;
   logic [SCALE_W-1:0]        crem_in;

   // Fraction stages.
   logic [FRAC_BITS-1:0]      fw_ff   [FRAC_BITS];
   logic [FRAC_BITS-1:0]      fw_in   [FRAC_BITS];
   logic [SCALE_W-1:0]        frem_ff [FRAC_BITS];
   logic [SCALE_W-1:0]        frem_in [FRAC_BITS];
   logic [SCALE_W-1:0]        fscl_ff [FRAC_BITS];
   logic signed [COORD_W-1:0] fcell_ff[FRAC_BITS];

   always_comb begin
      div_step_type st;
      logic [MAG_W-1:0]   w;
      logic [SCALE_W-1:0] r;
      logic [SCALE_W-1:0] sc;
      for (int k = 0; k < MAG_W; k++) begin
         w  = (k == 0) ? mag0_ff : qw_ff[k-1];
         r  = (k == 0) ? '0 : qrem_ff[k-1];
         sc = (k == 0) ? scl0_ff : qscl_ff[k-1];
         st = div_step(r, w[MAG_W-1], sc);
         qw_in[k]   = {w[MAG_W-2:0], st.qbit};
         qrem_in[k] = st.rem;
      end
   end

   // Floor correction: for c = -n-1, cell = -q-1 and remainder = scale-1-r.
   always_comb begin
      if (qneg_ff[MAG_W-1]) begin
         ccell_in = ~{1'b0, qw_ff[MAG_W-1]};
         crem_in  = qscl_ff[MAG_W-1] - 16'd1 - qrem_ff[MAG_W-1];
      end else begin
         ccell_in = {1'b0, qw_ff[MAG_W-1]};
         crem_in  = qrem_ff[MAG_W-1];
      end
   end

   always_comb begin
      div_step_type st;
      logic [FRAC_BITS-1:0] w;
      logic [SCALE_W-1:0]   r;
      logic [SCALE_W-1:0]   sc;
      for (int k = 0; k < FRAC_BITS; k++) begin
         w  = (k == 0) ? '0 : fw_ff[k-1];
         r  = (k == 0) ? crem_ff : frem_ff[k-1];
         sc = (k == 0) ? cscl_ff : fscl_ff[k-1];
         st = div_step(r, 1'b0, sc);
         fw_in[k]   = {w[FRAC_BITS-2:0], st.qbit};
         frem_in[k] = st.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg0_ff <= coord[COORD_W-1];
         mag0_ff <= coord[COORD_W-1] ? ~coord[MAG_W-1:0] : coord[MAG_W-1:0];
         scl0_ff <= (scale == '0) ? 16'd1 : scale;
         for (int k = 0; k < MAG_W; k++) begin
            qw_ff[k]   <= qw_in[k];
            qrem_ff[k] <= qrem_in[k];
            qscl_ff[k] <= (k == 0) ? scl0_ff : qscl_ff[k-1];
            qneg_ff[k] <= (k == 0) ? neg0_ff : qneg_ff[k-1];
         end
         ccell_ff <= ccell_in;
         crem_ff  <= crem_in;
         cscl_ff  <= qscl_ff[MAG_W-1];
         for (int k = 0; k < FRAC_BITS; k++) begin
            fw_ff[k]    <= fw_in[k];
            frem_ff[k]  <= frem_in[k];
            fscl_ff[k]  <= (k == 0) ? cscl_ff : fscl_ff[k-1];
            fcell_ff[k] <= (k == 0) ? ccell_ff : fcell_ff[k-1];
         end
      end
   end

   assign cell_idx = fcell_ff[FRAC_BITS-1];
   assign frac     = fw_ff[FRAC_BITS-1];

endmodule

FILE: design/vnh_mix64.sv
// Four-stage splitmix64 finalizer; each 64-bit product is split into 32-bit partial products.
// Depends on vnh_pkg.
module vnh_mix64 import vnh_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [WORD_W-1:0] v_in,
   output logic [WORD_W-1:0] v_out
);

   logic [WORD_W-1:0] x1;
   logic [WORD_W-1:0] p0a_ff;
   logic [HALF_W-1:0] p1a_ff;
   logic [HALF_W-1:0] p2a_ff;
   logic [WORD_W-1:0] prod1;
   logic [WORD_W-1:0] y_ff;
   logic [WORD_W-1:0] p0b_ff;
   logic [HALF_W-1:0] p1b_ff;
   logic [HALF_W-1:0] p2b_ff;
   logic [WORD_W-1:0] prod2;
   logic [WORD_W-1:0] out_ff;

   assign x1    = v_in ^ (v_in >> 30);
   assign prod1 = p0a_ff + {p1a_ff + p2a_ff, {HALF_W{1'b0}}};
   assign prod2 = p0b_ff + {p1b_ff + p2b_ff, {HALF_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         p0a_ff <= WORD_W'(x1[HALF_W-1:0]) * WORD_W'(MIX_C1[HALF_W-1:0]);
         p1a_ff <= HALF_W'(x1[WORD_W-1:HALF_W] * MIX_C1[HALF_W-1:0]);
         p2a_ff <= HALF_W'(x1[HALF_W-1:0] * MIX_C1[WORD_W-1:HALF_W]);
         y_ff   <= prod1 ^ (prod1 >> 27);
         p0b_ff <= WORD_W'(y_ff[HALF_W-1:0]) * WORD_W'(MIX_C2[HALF_W-1:0]);
         p1b_ff <= HALF_W'(y_ff[WORD_W-1:HALF_W] * MIX_C2[HALF_W-1:0]);
         p2b_ff <= HALF_W'(y_ff[HALF_W-1:0] * MIX_C2[WORD_W-1:HALF_W]);
         out_ff <= prod2 ^ (prod2 >> 31);
      end
   end

   assign v_out = out_ff;

endmodule

FILE: design/vnh_smooth.sv
// Three-stage smoothstep 3t^2 - 2t^3 on a Q0.FRAC_BITS fraction, capped below one.
// Depends on vnh_pkg.
module vnh_smooth import vnh_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [FRAC_BITS-1:0] t_in,
   output logic [FRAC_BITS-1:0] s_out
);

   logic [FRAC_BITS-1:0]   t1_ff;
   logic [FRAC_BITS-1:0]   t2_ff;
   logic [FRAC_BITS-1:0]   t2b_ff;
   logic [FRAC_BITS-1:0]   t3_ff;
   logic [2*FRAC_BITS-1:0] sq;
   logic [2*FRAC_BITS-1:0] cu;
   logic [FRAC_BITS+1:0]   poly;
   logic [FRAC_BITS-1:0]   s_ff;

   assign sq   = (2*FRAC_BITS)'(t_in) * (2*FRAC_BITS)'(t_in);
   assign cu   = (2*FRAC_BITS)'(t2_ff) * (2*FRAC_BITS)'(t1_ff);
   // t3 never exceeds t2, so the difference stays positive.
   assign poly = (FRAC_BITS+2)'(3 * t2b_ff - 2 * t3_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff  <= t_in;
         t2_ff  <= sq[FRAC_BITS +: FRAC_BITS];
         t2b_ff <= t2_ff;
         t3_ff  <= cu[FRAC_BITS +: FRAC_BITS];
         s_ff   <= (poly[FRAC_BITS+1:FRAC_BITS] != 2'b00) ? {FRAC_BITS{1'b1}}
                                                          : poly[FRAC_BITS-1:0];
      end
   end

   assign s_out = s_ff;

endmodule

FILE: design/value_noise_2d_hashed.sv
// Top level of the hashed 2D value noise block: register file, pipeline control, corner hashing and blend.
// Depends on vnh_pkg, vnh_divider, vnh_mix64 and vnh_smooth.
//
// Usage: an item on the req_ channel carries a signed coordinate pair. Each item
// gives exactly one rsp_ item holding the blended noise value in Q0.16. Both channels
// use valid/ready. The pipeline accepts one item per cycle while req_ready is high.
// Two 49-stage bit-serial dividers split each coordinate into cell and fraction (one
// quotient or fraction bit per stage); that chain sets most of the latency. The corner
// hashes then run through two rounds of four-stage splitmix64 units, and two blend
// stages finish. When the receiver stalls, the whole pipeline holds in place and
// req_ready drops in the same cycle, so no item is lost or repeated; when rsp_ready is
// high the block sustains one item per cycle. Reset clears all valid bits and loads the
// register reset values (seed 0, salt 1938907459, scale 96). Registers may only be
// written while the pipeline is empty; a scale of zero is treated as one. The mixed
// seed is recomputed continuously by a free-running splitmix64 unit from the seed
// register.
module value_noise_2d_hashed import vnh_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_W-1:0]  req_coord_x,
   input  logic signed [COORD_W-1:0]  req_coord_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [CORNER_W-1:0]        rsp_noise_value,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   // Blend of two corner values by a smoothed fraction, truncated.
   function automatic logic [CORNER_W-1:0] lerp_q(input logic [CORNER_W-1:0] a,
                                                  input logic [CORNER_W-1:0] b,
                                                  input logic [FRAC_BITS-1:0] s);
      logic [FRAC_BITS:0]          w;
      logic [CORNER_W+FRAC_BITS:0] acc;
      w   = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, s};
      acc = (CORNER_W+FRAC_BITS+1)'(a) * (CORNER_W+FRAC_BITS+1)'(w)
          + (CORNER_W+FRAC_BITS+1)'(b) * (CORNER_W+FRAC_BITS+1)'(s);
      return acc[FRAC_BITS +: CORNER_W];
   endfunction

   // ---------------- Configuration registers ----------------
   logic [WORD_W-1:0]  seed_ff;
   logic [WORD_W-1:0]  salt_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               csr_write;
   reg_index_type      csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= SEED_RESET;
         salt_ff  <= SALT_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_WORLD_SEED: seed_ff  <= csr_pwdata;
            REG_NOISE_SALT: salt_ff  <= csr_pwdata;
            REG_CELL_SCALE: scale_ff <= csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WORLD_SEED: csr_prdata = seed_ff;
         REG_NOISE_SALT: csr_prdata = salt_ff;
         REG_CELL_SCALE: csr_prdata = {{(CSR_DATA_W-SCALE_W){1'b0}}, scale_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------- Pipeline control ----------------
   // The whole pipeline advances together; it freezes only when a finished item waits.
   logic                en;
   logic [PIPE_LAT-1:0] vld_ff;

   assign en        = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   // ---------------- Cell and fraction ----------------
   logic signed [COORD_W-1:0] cell_x;
   logic signed [COORD_W-1:0] cell_z;
   logic [FRAC_BITS-1:0]      frac_x;
   logic [FRAC_BITS-1:0]      frac_z;

   vnh_divider u_div_x (
      .clock    (clock), .en (en), .coord (req_coord_x), .scale (scale_ff),
      .cell_idx (cell_x), .frac (frac_x)
   );

   vnh_divider u_div_z (
      .clock    (clock), .en (en), .coord (req_coord_z), .scale (scale_ff),
      .cell_idx (cell_z), .frac (frac_z)
   );

   // ---------------- Corner hashing ----------------
   // The seed hash only depends on a register, so it runs free.
   logic [WORD_W-1:0] seed_mix;

   vnh_mix64 u_mix_seed (.clock (clock), .en (1'b1), .v_in (seed_ff), .v_out (seed_mix));

   // Lattice offsets of both neighbor columns and rows, 64-bit two's complement.
   logic [WORD_W-1:0] hx0_ff, hx1_ff, hz0_ff, hz1_ff;
   logic [WORD_W-1:0] mx0, mx1, mz0, mz1;

   always_ff @(posedge clock) begin
      if (en) begin
         hx0_ff <= WORD_W'(cell_x) + HASH_KX;
         hx1_ff <= WORD_W'(cell_x) + HASH_KX1;
         hz0_ff <= WORD_W'(cell_z) + HASH_KZ;
         hz1_ff <= WORD_W'(cell_z) + HASH_KZ1;
      end
   end

   vnh_mix64 u_mix_x0 (.clock (clock), .en (en), .v_in (hx0_ff), .v_out (mx0));
   vnh_mix64 u_mix_x1 (.clock (clock), .en (en), .v_in (hx1_ff), .v_out (mx1));
   vnh_mix64 u_mix_z0 (.clock (clock), .en (en), .v_in (hz0_ff), .v_out (mz0));
   vnh_mix64 u_mix_z1 (.clock (clock), .en (en), .v_in (hz1_ff), .v_out (mz1));

   // Corner order: a = (x, z), b = (x+1, z), c = (x, z+1), d = (x+1, z+1).
   logic [WORD_W-1:0] key;
   logic [WORD_W-1:0] ha_ff, hb_ff, hc_ff, hd_ff;
   logic [WORD_W-1:0] fa, fb, fc, fd;

   assign key = seed_mix ^ salt_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ha_ff <= key ^ mx0 ^ mz0;
         hb_ff <= key ^ mx1 ^ mz0;
         hc_ff <= key ^ mx0 ^ mz1;
         hd_ff <= key ^ mx1 ^ mz1;
      end
   end

   vnh_mix64 u_mix_a (.clock (clock), .en (en), .v_in (ha_ff), .v_out (fa));
   vnh_mix64 u_mix_b (.clock (clock), .en (en), .v_in (hb_ff), .v_out (fb));
   vnh_mix64 u_mix_c (.clock (clock), .en (en), .v_in (hc_ff), .v_out (fc));
   vnh_mix64 u_mix_d (.clock (clock), .en (en), .v_in (hd_ff), .v_out (fd));

   // ---------------- Smoothed fractions ----------------
   // Delayed so that sx meets the corner values and sz meets the outputs of the first blend.
   localparam int SX_DLY = HASH_LAT - SMOOTH_LAT;
   localparam int SZ_DLY = SX_DLY + 1;

   logic [FRAC_BITS-1:0] sx, sz;
   logic [FRAC_BITS-1:0] sx_dly_ff [SX_DLY];
   logic [FRAC_BITS-1:0] sz_dly_ff [SZ_DLY];

   vnh_smooth u_smooth_x (.clock (clock), .en (en), .t_in (frac_x), .s_out (sx));
   vnh_smooth u_smooth_z (.clock (clock), .en (en), .t_in (frac_z), .s_out (sz));

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SX_DLY; k++) begin
            sx_dly_ff[k] <= (k == 0) ? sx : sx_dly_ff[k-1];
         end
         for (int k = 0; k < SZ_DLY; k++) begin
            sz_dly_ff[k] <= (k == 0) ? sz : sz_dly_ff[k-1];
         end
      end
   end

   // ---------------- Bilinear blend ----------------
   logic [CORNER_W-1:0] top_ff, bot_ff, noise_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         top_ff   <= lerp_q(fa[WORD_W-1 -: CORNER_W], fb[WORD_W-1 -: CORNER_W],
                            sx_dly_ff[SX_DLY-1]);
         bot_ff   <= lerp_q(fc[WORD_W-1 -: CORNER_W], fd[WORD_W-1 -: CORNER_W],
                            sx_dly_ff[SX_DLY-1]);
         noise_ff <= lerp_q(top_ff, bot_ff, sz_dly_ff[SZ_DLY-1]);
      end
   end

   assign rsp_noise_value = noise_ff;

endmodule
